>>> sv/cbdt_pkg.sv
`timescale 1ns / 1ps

package cbdt_pkg;

  // Data format constants.
  localparam int COORD_BITS      = 24;
  localparam int COORD_FRAC_BITS = 10;
  localparam int COUNT_BITS      = 24;

  // Fixed widths of the interface fields.
  localparam int ELEM_W = 8;
  localparam int PE_W   = 24;
  localparam int DSQ_W  = 61;
  localparam int CFG_W  = 24;
  localparam int CIDX_W = 2;
  localparam int SCALE_W  = 9;
  localparam int BUDGET_W = 24;

  // Derived datapath widths.
  localparam int MAG_W  = COORD_BITS + 4;   // magnitude after the optional x10
  localparam int RAD_W  = 8;                // one covalent radius, 0.01 A units
  localparam int RSUM_W = RAD_W + 1;
  localparam int PROD_W = SCALE_W + RSUM_W;
  localparam int K_W    = 2 * PROD_W;
  localparam int SQ_W   = 61;               // axis square, capped at 2^60
  localparam int SUM_W  = SQ_W + 2;
  localparam int TWO_F  = 2 * COORD_FRAC_BITS;
  localparam int LSH    = (TWO_F < 20) ? 20 - TWO_F : 0;
  localparam int RSH    = (TWO_F > 20) ? TWO_F - 20 : 0;

  // Scale clamp limits, in 1/256.
  localparam logic [SCALE_W-1:0] SCALE_MIN = SCALE_W'(256);
  localparam logic [SCALE_W-1:0] SCALE_MAX = SCALE_W'(384);

  // Register indexes on the configuration port.
  localparam logic [CIDX_W-1:0] REG_INFER_ENABLE    = 2'd0;
  localparam logic [CIDX_W-1:0] REG_RADIUS_SCALE    = 2'd1;
  localparam logic [CIDX_W-1:0] REG_PAIR_BUDGET     = 2'd2;
  localparam logic [CIDX_W-1:0] REG_NANOMETER_UNITS = 2'd3;

  // Result outcome codes.
  typedef enum logic [1:0] {
    OUT_SKIP      = 2'd0,
    OUT_NO_BOND   = 2'd1,
    OUT_BOND      = 2'd2,
    OUT_EXHAUSTED = 2'd3
  } outcome_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic diff_en;
    logic sqr_en;
    logic sum_en;
    logic out_load;
  } cbdt_cmd_t;

  // Covalent radius in 0.01 A; zero marks an unsupported element.
  function automatic logic [RAD_W-1:0] radius_of(input logic [ELEM_W-1:0] z);
    logic [RAD_W-1:0] r;
    case (z)
      8'd1:    r = 8'd31;
      8'd5:    r = 8'd84;
      8'd6:    r = 8'd76;
      8'd7:    r = 8'd71;
      8'd8:    r = 8'd66;
      8'd9:    r = 8'd57;
      8'd14:   r = 8'd111;
      8'd15:   r = 8'd107;
      8'd16:   r = 8'd105;
      8'd17:   r = 8'd102;
      8'd35:   r = 8'd120;
      8'd53:   r = 8'd139;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

>>> sv/cbdt_ctrl.sv
`timescale 1ns / 1ps

module cbdt_ctrl import cbdt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output cbdt_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIFF = 5'b00010,
    ST_SQR  = 5'b00100,
    ST_SUM  = 5'b01000,
    ST_CMP  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // The output register is free when empty or being emptied in this cycle.
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state and datapath commands.
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd.diff_en = 1'b1;
        state_nxt   = ST_SQR;
      end
      ST_SQR: begin
        cmd.sqr_en = 1'b1;
        state_nxt  = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_en = 1'b1;
        state_nxt  = ST_CMP;
      end
      ST_CMP: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result valid flag: set on a load, cleared once the transfer completes.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> sv/cbdt_datapath.sv
`timescale 1ns / 1ps

module cbdt_datapath import cbdt_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cbdt_cmd_t                    cmd,
  // Configuration writes.
  input  logic                         cfg_we,
  input  logic [CIDX_W-1:0]            cfg_index,
  input  logic [CFG_W-1:0]             cfg_wdata,
  // Input item fields.
  input  logic                         in_start_of_set,
  input  logic [ELEM_W-1:0]            in_first_element,
  input  logic [ELEM_W-1:0]            in_second_element,
  input  logic                         in_first_present,
  input  logic                         in_second_present,
  input  logic                         in_already_bonded,
  input  logic signed [COORD_BITS-1:0] in_first_x,
  input  logic signed [COORD_BITS-1:0] in_first_y,
  input  logic signed [COORD_BITS-1:0] in_first_z,
  input  logic signed [COORD_BITS-1:0] in_second_x,
  input  logic signed [COORD_BITS-1:0] in_second_y,
  input  logic signed [COORD_BITS-1:0] in_second_z,
  // Result item fields.
  output logic [1:0]                   out_outcome,
  output logic [DSQ_W-1:0]             out_distance_squared,
  output logic [PE_W-1:0]              out_pairs_evaluated
);

  // Configuration registers.
  logic                infer_enable_r;
  logic [SCALE_W-1:0]  radius_scale_r;
  logic [BUDGET_W-1:0] pair_budget_r;
  logic                nanometer_units_r;

  // Set state.
  logic [COUNT_BITS-1:0] pair_count_r, pair_count_nxt;
  logic                  exhausted_r, exhausted_nxt;

  // Item registers.
  outcome_t                     outcome_r, outcome_nxt;
  logic                         compute_r, compute_nxt;
  logic [RSUM_W-1:0]            rsum_r;
  logic signed [COORD_BITS-1:0] a_r [3];
  logic signed [COORD_BITS-1:0] b_r [3];
  logic [MAG_W-1:0]             mag_r [3];
  logic [PROD_W-1:0]            prod_r;
  logic [SQ_W-1:0]              sq_r [3];
  logic [K_W-1:0]               k_r;
  logic [DSQ_W-1:0]             dsq_r;

  // Output register.
  logic [1:0]       out_outcome_r;
  logic [DSQ_W-1:0] out_dsq_r;
  logic [PE_W-1:0]  out_pe_r;

  // Configuration writes; the user must write the port only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      infer_enable_r    <= 1'b1;
      radius_scale_r    <= SCALE_W'(256);
      pair_budget_r     <= '1;
      nanometer_units_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INFER_ENABLE:    infer_enable_r    <= cfg_wdata[0];
        REG_RADIUS_SCALE:    radius_scale_r    <= cfg_wdata[SCALE_W-1:0];
        REG_PAIR_BUDGET:     pair_budget_r     <= cfg_wdata[BUDGET_W-1:0];
        REG_NANOMETER_UNITS: nanometer_units_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Classification of the pair and budget bookkeeping at the transfer.
  logic [RAD_W-1:0]      r1, r2;
  logic [COUNT_BITS-1:0] count_base;
  logic                  exh_base, eligible, at_limit;

  always_comb begin
    r1         = radius_of(in_first_element);
    r2         = radius_of(in_second_element);
    count_base = in_start_of_set ? '0 : pair_count_r;
    exh_base   = in_start_of_set ? 1'b0 : exhausted_r;
    eligible   = infer_enable_r && in_first_present && (r1 != '0) &&
                 in_second_present && !in_already_bonded;
    at_limit   = (32'(count_base) >= 32'(pair_budget_r)) || (&count_base);

    pair_count_nxt = count_base;
    exhausted_nxt  = exh_base;
    outcome_nxt    = OUT_SKIP;
    compute_nxt    = 1'b0;
    if (exh_base) begin
      outcome_nxt = OUT_EXHAUSTED;
    end else if (eligible) begin
      if (at_limit) begin
        exhausted_nxt = 1'b1;
        outcome_nxt   = OUT_EXHAUSTED;
      end else begin
        pair_count_nxt = count_base + 1'b1;
        outcome_nxt    = OUT_NO_BOND;
        compute_nxt    = (r2 != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_count_r <= '0;
      exhausted_r  <= 1'b0;
    end else if (cmd.load) begin
      pair_count_r <= pair_count_nxt;
      exhausted_r  <= exhausted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      outcome_r <= outcome_nxt;
      compute_r <= compute_nxt;
      rsum_r    <= RSUM_W'(r1) + RSUM_W'(r2);
      a_r[0]    <= in_first_x;
      a_r[1]    <= in_first_y;
      a_r[2]    <= in_first_z;
      b_r[0]    <= in_second_x;
      b_r[1]    <= in_second_y;
      b_r[2]    <= in_second_z;
    end
  end

  // Axis magnitudes, scaled by ten for nanometre input, and the scaled radius sum.
  logic signed [COORD_BITS:0] diff [3];
  logic [COORD_BITS:0]        absd [3];
  logic [MAG_W-1:0]           mag  [3];
  logic [SCALE_W-1:0]         sc;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = (COORD_BITS+1)'(a_r[i]) - (COORD_BITS+1)'(b_r[i]);
      absd[i] = diff[i][COORD_BITS] ? (COORD_BITS+1)'(-diff[i]) : diff[i];
      mag[i]  = MAG_W'(absd[i]);
      if (nanometer_units_r) begin
        mag[i] = (mag[i] << 3) + (mag[i] << 1);
      end
    end
    sc = radius_scale_r;
    if (sc < SCALE_MIN) begin
      sc = SCALE_MIN;
    end else if (sc > SCALE_MAX) begin
      sc = SCALE_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.diff_en) begin
      for (int i = 0; i < 3; i++) begin
        mag_r[i] <= mag[i];
      end
      prod_r <= PROD_W'(sc) * PROD_W'(rsum_r);
    end
  end

  // Axis squares, each capped at 2^60, and the squared cutoff.
  logic [63:0] mag_ext [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_ext[i] = 64'(mag_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqr_en) begin
      for (int i = 0; i < 3; i++) begin
        if (mag_ext[i] >= (64'd1 << 30)) begin
          sq_r[i] <= SQ_W'(1) << 60;
        end else begin
          sq_r[i] <= SQ_W'(mag_ext[i][29:0]) * SQ_W'(mag_ext[i][29:0]);
        end
      end
      k_r <= K_W'(prod_r) * K_W'(prod_r);
    end
  end

  // Sum of squares, saturated at 2^60.
  logic [SUM_W-1:0] sum;

  assign sum = SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      if (sum > (SUM_W'(1) << 60)) begin
        dsq_r <= DSQ_W'(1) << 60;
      end else begin
        dsq_r <= DSQ_W'(sum);
      end
    end
  end

  // Distance window test on squared values and the final outcome.
  logic [63:0] dsq_lo, near_lhs, near_rhs, far_lhs, far_rhs;
  logic        dsq_small, above_min, in_reach;
  outcome_t    final_outcome;
  logic [DSQ_W-1:0] final_dsq;

  always_comb begin
    dsq_small = (dsq_r < (DSQ_W'(1) << 40));
    dsq_lo    = 64'(dsq_r[39:0]);
    near_lhs  = dsq_lo * 64'd100;
    near_rhs  = 64'd16 << TWO_F;
    far_lhs   = (dsq_lo * 64'd625) << LSH;
    far_rhs   = 64'(k_r) << RSH;
    above_min = (near_lhs >= near_rhs);
    in_reach  = (far_lhs <= far_rhs);
    final_outcome = outcome_r;
    final_dsq     = '0;
    if (compute_r) begin
      final_dsq = dsq_r;
      if (dsq_small && above_min && in_reach) begin
        final_outcome = OUT_BOND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_outcome_r <= final_outcome;
      out_dsq_r     <= final_dsq;
      out_pe_r      <= PE_W'(pair_count_r);
    end
  end

  assign out_outcome          = out_outcome_r;
  assign out_distance_squared = out_dsq_r;
  assign out_pairs_evaluated  = out_pe_r;

endmodule

>>> sv/covalent_bond_distance_test.sv
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// in        in_valid / in_ready    start flag, elements, presence, bonded, coordinates
// out       out_valid / out_ready  outcome, distance_squared, pairs_evaluated
// cfg       cfg_we                 cfg_index, cfg_wdata (no wait, no read-back)
//
// An item passes through one transfer step, then difference, square, sum and
// compare steps of the controller, one item in flight at a time.
// Reset is synchronous and active low; it restores the register defaults and
// clears the pair count and the exhausted flag.
// A result held in the output register does not block the next input transfer;
// the compare step waits only when the output register is still full.

module covalent_bond_distance_test import cbdt_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CIDX_W-1:0]            cfg_index,
  input  logic [CFG_W-1:0]             cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_start_of_set,
  input  logic [ELEM_W-1:0]            in_first_element,
  input  logic [ELEM_W-1:0]            in_second_element,
  input  logic                         in_first_present,
  input  logic                         in_second_present,
  input  logic                         in_already_bonded,
  input  logic signed [COORD_BITS-1:0] in_first_x,
  input  logic signed [COORD_BITS-1:0] in_first_y,
  input  logic signed [COORD_BITS-1:0] in_first_z,
  input  logic signed [COORD_BITS-1:0] in_second_x,
  input  logic signed [COORD_BITS-1:0] in_second_y,
  input  logic signed [COORD_BITS-1:0] in_second_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_outcome,
  output logic [DSQ_W-1:0]             out_distance_squared,
  output logic [PE_W-1:0]              out_pairs_evaluated
);

  cbdt_cmd_t cmd;

  // Sequencing of one pair through the datapath.
  cbdt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Distance arithmetic, set bookkeeping and the output register.
  cbdt_datapath u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_start_of_set      (in_start_of_set),
    .in_first_element     (in_first_element),
    .in_second_element    (in_second_element),
    .in_first_present     (in_first_present),
    .in_second_present    (in_second_present),
    .in_already_bonded    (in_already_bonded),
    .in_first_x           (in_first_x),
    .in_first_y           (in_first_y),
    .in_first_z           (in_first_z),
    .in_second_x          (in_second_x),
    .in_second_y          (in_second_y),
    .in_second_z          (in_second_z),
    .out_outcome          (out_outcome),
    .out_distance_squared (out_distance_squared),
    .out_pairs_evaluated  (out_pairs_evaluated)
  );

endmodule
